>>> hdl/c3zp_pkg.sv
package c3zp_pkg;

   localparam int PIX_W      = 8;
   localparam int COEF_REG_W = 24;
   localparam int SIZE_W     = 11;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = 12;
   localparam int IN_ROW_W   = 11;
   localparam int TAPS       = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [IN_ROW_W-1:0] IN_ROW_MAX = 11'd2047;
   localparam logic [PIX_W-1:0]    PIX_MAX    = 8'd255;

   localparam logic [COEF_REG_W-1:0] COEF_TOP_RST = 24'h000000;
   localparam logic [COEF_REG_W-1:0] COEF_MID_RST = 24'h000100;
   localparam logic [COEF_REG_W-1:0] COEF_BOT_RST = 24'h000000;
   localparam logic [SIZE_W-1:0]     WIDTH_RST    = 11'd1024;
   localparam logic [SIZE_W-1:0]     HEIGHT_RST   = 11'd1024;
   localparam logic [GAIN_W-1:0]     GAIN_RST     = 16'd4096;

   localparam int OUTQ_DEPTH = 8;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = OUTQ_AW + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_TOP,
      CSR_COEF_MID,
      CSR_COEF_BOT,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_NORM_GAIN
   } csr_index_type;

   // Per-beat decision made by the position counters when a beat is taken.
   typedef struct packed {
      logic             act;
      logic             emit;
      logic             last;
      logic [PIX_W-1:0] pixel;
      logic [TAPS-1:0]  mask;
   } item_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } result_type;

endpackage

>>> hdl/conv3x3_zero_padded_filter.sv
// 3x3 convolution over an 8-bit grayscale stream in raster order with zero padding
// at the image borders, a Q4.12 gain, and clamping to 0..255. The filter takes one
// pixel beat per clock while req_stall is low: each beat reads and writes back one
// column of a line RAM of MAX_WIDTH words that holds the two previous rows, and a
// write is forwarded to a read of the same column in the same cycle. A result goes
// through registers s1 to s6 after the beat that completes its window and leaves
// through an eight-entry output queue. A queue slot is claimed when that beat is
// taken, so the input is stalled only when eight results are in the pipeline or
// waiting in the queue, which happens only while the output is stalled. The result
// for a pixel is produced by the beat that arrives width+1 beats after it; after
// the last pixel, width+1 drain beats (or any beats) flush the rest of the image.
// Drain beats are dropped until every row has come in. The line RAM needs no clearing
// after reset: a fill mark makes columns not yet written since reset read as zero.
module conv3x3_zero_padded_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COEF_BITS  = 8
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [c3zp_pkg::PIX_W-1:0]        req_pixel_in,
   input  logic                              req_drain,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [c3zp_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic                              rsp_image_last,

   input  logic                              csr_write_en,
   input  logic [c3zp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [c3zp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import c3zp_pkg::*;

   logic [COEF_REG_W-1:0] coef_top_ff, coef_top_in;
   logic [COEF_REG_W-1:0] coef_mid_ff, coef_mid_in;
   logic [COEF_REG_W-1:0] coef_bot_ff, coef_bot_in;
   logic [SIZE_W-1:0]     width_ff, width_in;
   logic [SIZE_W-1:0]     height_ff, height_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;

   logic                          accept;
   logic                          room;
   item_type                      item;
   logic [$clog2(MAX_WIDTH)-1:0]  rd_addr;
   logic [2:0][COEF_REG_W-1:0]    coef_rows;
   logic                          push;
   result_type                    push_data;
   result_type                    rsp_data;

   always_comb begin
      coef_top_in = coef_top_ff;
      coef_mid_in = coef_mid_ff;
      coef_bot_in = coef_bot_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      gain_in     = gain_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_TOP:     coef_top_in = csr_wdata;
            CSR_COEF_MID:     coef_mid_in = csr_wdata;
            CSR_COEF_BOT:     coef_bot_in = csr_wdata;
            CSR_IMAGE_WIDTH:  width_in    = csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT: height_in   = csr_wdata[SIZE_W-1:0];
            CSR_NORM_GAIN:    gain_in     = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= COEF_TOP_RST;
         coef_mid_ff <= COEF_MID_RST;
         coef_bot_ff <= COEF_BOT_RST;
         width_ff    <= WIDTH_RST;
         height_ff   <= HEIGHT_RST;
         gain_ff     <= GAIN_RST;
      end else begin
         coef_top_ff <= coef_top_in;
         coef_mid_ff <= coef_mid_in;
         coef_bot_ff <= coef_bot_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         gain_ff     <= gain_in;
      end
   end

   assign req_stall = !room;
   assign accept    = req_valid && room;
   assign coef_rows = {coef_bot_ff, coef_mid_ff, coef_top_ff};

   c3zp_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel_in     (req_pixel_in),
      .drain        (req_drain),
      .image_width  (width_ff),
      .image_height (height_ff),
      .item         (item),
      .rd_addr      (rd_addr)
   );

   c3zp_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .COEF_BITS (COEF_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .rd_addr   (rd_addr),
      .coef_rows (coef_rows),
      .norm_gain (gain_ff),
      .push      (push),
      .push_data (push_data)
   );

   c3zp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .reserve   (accept && item.emit),
      .push      (push),
      .push_data (push_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .room      (room)
   );

   assign rsp_pixel_out  = rsp_data.pixel;
   assign rsp_image_last = rsp_data.last;

endmodule

>>> hdl/c3zp_ram.sv
module c3zp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read and a write to the same address in one cycle return the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/c3zp_ctrl.sv
module c3zp_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [c3zp_pkg::PIX_W-1:0]      pixel_in,
   input  logic                            drain,
   input  logic [c3zp_pkg::SIZE_W-1:0]     image_width,
   input  logic [c3zp_pkg::SIZE_W-1:0]     image_height,
   output c3zp_pkg::item_type              item,
   output logic [$clog2(MAX_WIDTH)-1:0]    rd_addr
);

   import c3zp_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int OROW_W = $clog2(MAX_HEIGHT);
   localparam int WC_W   = (SIZE_W > $clog2(MAX_WIDTH + 1)) ? SIZE_W : $clog2(MAX_WIDTH + 1);
   localparam int HC_W   = (SIZE_W > $clog2(MAX_HEIGHT + 1)) ? SIZE_W
                                                              : $clog2(MAX_HEIGHT + 1);

   logic [COL_W-1:0]    in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]    out_col_ff, out_col_in;
   logic [OROW_W-1:0]   out_row_ff, out_row_in;

   logic [WC_W-1:0] width_use, in_col_nx, out_col_nx;
   logic [HC_W-1:0] height_use, out_row_nx;
   logic            flushing, act, emit, last;
   logic            in_col_end, out_col_end, out_row_end;
   logic [2:0]      row_ok, col_ok;

   always_comb begin
      if (image_width == '0) begin
         width_use = WC_W'(1);
      end else if (WC_W'(image_width) > WC_W'(MAX_WIDTH)) begin
         width_use = WC_W'(MAX_WIDTH);
      end else begin
         width_use = WC_W'(image_width);
      end
      if (image_height == '0) begin
         height_use = HC_W'(1);
      end else if (HC_W'(image_height) > HC_W'(MAX_HEIGHT)) begin
         height_use = HC_W'(MAX_HEIGHT);
      end else begin
         height_use = HC_W'(image_height);
      end

      in_col_nx   = WC_W'(in_col_ff) + WC_W'(1);
      out_col_nx  = WC_W'(out_col_ff) + WC_W'(1);
      out_row_nx  = HC_W'(out_row_ff) + HC_W'(1);
      in_col_end  = in_col_nx >= width_use;
      out_col_end = out_col_nx >= width_use;
      out_row_end = out_row_nx >= height_use;

      // Once all rows are in, every beat is a flush beat and carries a zero pixel.
      flushing = HC_W'(in_row_ff) >= height_use;
      act      = !(drain && !flushing);
      emit     = act && ((in_row_ff >= IN_ROW_W'(2)) ||
                         ((in_row_ff == IN_ROW_W'(1)) && (in_col_ff != '0)));
      last     = out_row_end && out_col_end;

      row_ok = {!out_row_end, 1'b1, out_row_ff != '0};
      col_ok = {!out_col_end, 1'b1, out_col_ff != '0};

      item.act   = act;
      item.emit  = emit;
      item.last  = last;
      item.pixel = flushing ? '0 : pixel_in;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            item.mask[r*3 + k] = row_ok[r] && col_ok[k];
         end
      end

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept && act) begin
         if (in_col_end) begin
            in_col_in = '0;
            if (in_row_ff != IN_ROW_MAX) begin
               in_row_in = in_row_ff + IN_ROW_W'(1);
            end
         end else begin
            in_col_in = COL_W'(in_col_nx);
         end
      end
      if (accept && emit) begin
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (out_col_end) begin
            out_col_in = '0;
            out_row_in = OROW_W'(out_row_nx);
         end else begin
            out_col_in = COL_W'(out_col_nx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   assign rd_addr = in_col_ff;

endmodule

>>> hdl/c3zp_datapath.sv
module c3zp_datapath #(
   parameter int MAX_WIDTH = 1024,
   parameter int COEF_BITS = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      accept,
   input  c3zp_pkg::item_type                        item,
   input  logic [$clog2(MAX_WIDTH)-1:0]              rd_addr,
   input  logic [2:0][c3zp_pkg::COEF_REG_W-1:0]      coef_rows,
   input  logic [c3zp_pkg::GAIN_W-1:0]               norm_gain,
   output logic                                      push,
   output c3zp_pkg::result_type                      push_data
);

   import c3zp_pkg::*;

   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int FILL_W = $clog2(MAX_WIDTH + 1);
   localparam int LINE_W = 2 * PIX_W;
   localparam int PROD_W = COEF_BITS + PIX_W + 1;
   localparam int ROW_W  = PROD_W + 2;
   localparam int SUM_W  = PROD_W + 4;
   localparam int SCL_W  = SUM_W - 1 + GAIN_W;
   localparam int EXT_W  = (3 * COEF_BITS > COEF_REG_W) ? 3 * COEF_BITS : COEF_REG_W;

   // Line RAM word: upper byte is two rows back, lower byte is the previous row.
   logic              rd_en, wr_en;
   logic [LINE_W-1:0] rd_data, wr_data, line_data;

   logic              s1_act_ff, s1_act_in;
   item_type          s1_item_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic              fwd_ff, fwd_in;
   logic              blank_ff, blank_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [LINE_W-1:0] fwd_data_ff;
   logic [PIX_W-1:0]  window_ff [TAPS];

   logic              s2_valid_ff, s2_valid_in;
   logic              s2_last_ff;
   logic [TAPS-1:0]   s2_mask_ff;

   logic signed [COEF_BITS-1:0] coef_s [TAPS];
   logic signed [PIX_W:0]       pix_s  [TAPS];
   logic signed [PROD_W-1:0]    mult   [TAPS];
   logic signed [PROD_W-1:0]    s3_prod_ff [TAPS];
   logic signed [PROD_W-1:0]    s3_prod_in [TAPS];
   logic                        s3_valid_ff, s3_last_ff;

   logic signed [ROW_W-1:0]     s4_row_ff [3];
   logic signed [ROW_W-1:0]     s4_row_in [3];
   logic                        s4_valid_ff, s4_last_ff;

   logic signed [SUM_W-1:0]     s5_sum_ff, s5_sum_in;
   logic                        s5_valid_ff, s5_last_ff;

   logic [SCL_W-1:0]            s6_scl_ff, s6_scl_in;
   logic                        s6_valid_ff, s6_last_ff;

   c3zp_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_en = accept && item.act;

   // A beat whose read meets the previous beat's write on the same column takes
   // the write data instead of the stale RAM word.
   // Columns are written from zero upward, so every column at or above the fill
   // mark has never been written since reset and reads as zero.
   always_comb begin
      s1_act_in = accept && item.act;
      fwd_in    = s1_act_ff && (s1_addr_ff == rd_addr);
      blank_in  = FILL_W'(rd_addr) >= fill_ff;
      if (fwd_ff) begin
         line_data = fwd_data_ff;
      end else if (blank_ff) begin
         line_data = '0;
      end else begin
         line_data = rd_data;
      end
      wr_en     = s1_act_ff;
      wr_data   = {line_data[PIX_W-1:0], s1_item_ff.pixel};
      fill_in   = fill_ff;
      if (s1_act_ff && (FILL_W'(s1_addr_ff) >= fill_ff)) begin
         fill_in = FILL_W'(s1_addr_ff) + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_act_ff <= 1'b0;
         fwd_ff    <= 1'b0;
         blank_ff  <= 1'b1;
         fill_ff   <= '0;
      end else begin
         s1_act_ff <= s1_act_in;
         fill_ff   <= fill_in;
         if (accept) begin
            fwd_ff   <= fwd_in;
            blank_ff <= blank_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff  <= item;
         s1_addr_ff  <= rd_addr;
         fwd_data_ff <= wr_data;
      end
      if (s1_act_ff) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r*3]     <= window_ff[r*3 + 1];
            window_ff[r*3 + 1] <= window_ff[r*3 + 2];
         end
         window_ff[2] <= line_data[LINE_W-1:PIX_W];
         window_ff[5] <= line_data[PIX_W-1:0];
         window_ff[8] <= s1_item_ff.pixel;
      end
   end

   assign s2_valid_in = s1_act_ff && s1_item_ff.emit;

   always_ff @(posedge clock) begin
      s2_mask_ff <= s1_item_ff.mask;
      s2_last_ff <= s1_item_ff.last;
   end

   // Taps of the window: row r, column k at r*3+k, left column in the low field.
   for (genvar t = 0; t < TAPS; t++) begin : g_tap
      logic [EXT_W-1:0] row_ext;
      assign row_ext  = EXT_W'(coef_rows[t / 3]);
      assign coef_s[t] = $signed(row_ext[(t % 3) * COEF_BITS +: COEF_BITS]);
      assign pix_s[t]  = $signed({1'b0, window_ff[t]});
      assign mult[t]   = coef_s[t] * pix_s[t];
   end

   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         if (s2_mask_ff[t]) begin
            s3_prod_in[t] = mult[t];
         end else begin
            s3_prod_in[t] = '0;
         end
      end
      for (int r = 0; r < 3; r++) begin
         s4_row_in[r] = ROW_W'(s3_prod_ff[r*3]) + ROW_W'(s3_prod_ff[r*3 + 1]) +
                        ROW_W'(s3_prod_ff[r*3 + 2]);
      end
      s5_sum_in = SUM_W'(s4_row_ff[0]) + SUM_W'(s4_row_ff[1]) + SUM_W'(s4_row_ff[2]);
      if (s5_sum_ff[SUM_W-1] || (s5_sum_ff == '0)) begin
         s6_scl_in = '0;
      end else begin
         s6_scl_in = SCL_W'(s5_sum_ff[SUM_W-2:0]) * SCL_W'(norm_gain);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_prod_ff <= s3_prod_in;
      s3_last_ff <= s2_last_ff;
      s4_row_ff  <= s4_row_in;
      s4_last_ff <= s3_last_ff;
      s5_sum_ff  <= s5_sum_in;
      s5_last_ff <= s4_last_ff;
      s6_scl_ff  <= s6_scl_in;
      s6_last_ff <= s5_last_ff;
   end

   always_comb begin
      push           = s6_valid_ff;
      push_data.last = s6_last_ff;
      if (|s6_scl_ff[SCL_W-1:GAIN_FRAC+PIX_W]) begin
         push_data.pixel = PIX_MAX;
      end else begin
         push_data.pixel = s6_scl_ff[GAIN_FRAC +: PIX_W];
      end
   end

endmodule

>>> hdl/c3zp_outq.sv
module c3zp_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 reserve,
   input  logic                 push,
   input  c3zp_pkg::result_type push_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output c3zp_pkg::result_type rsp_data,
   output logic                 room
);

   import c3zp_pkg::*;

   result_type           entries_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CW-1:0]   count_ff, count_in;
   logic [OUTQ_CW-1:0]   used_ff, used_in;
   logic                 pop;

   // Slots are claimed when a beat that will yield a result enters the pipeline,
   // so results still in flight always find space here.
   always_comb begin
      rsp_valid = count_ff != '0;
      rsp_data  = entries_ff[rd_ptr_ff];
      room      = used_ff < OUTQ_CW'(OUTQ_DEPTH);
      pop       = rsp_valid && !rsp_stall;

      wr_ptr_in = push ? wr_ptr_ff + OUTQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + OUTQ_AW'(1) : rd_ptr_ff;

      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + OUTQ_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OUTQ_CW'(1);
      end

      used_in = used_ff;
      if (reserve && !pop) begin
         used_in = used_ff + OUTQ_CW'(1);
      end else if (pop && !reserve) begin
         used_in = used_ff - OUTQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> bench/testbench.sv
module testbench;
   import c3zp_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 1024;
   localparam int COEF_W        = 8;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS  = 350;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  req_drain    = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_image_last;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   // Shadow copy of the filter settings and of its pixel history.
   logic [COEF_REG_W-1:0] kernel_row [3];
   logic [SIZE_W-1:0]     width_reg;
   logic [SIZE_W-1:0]     height_reg;
   logic [GAIN_W-1:0]     gain_reg;
   logic [PIX_W-1:0]      line_m1 [MAX_W];
   logic [PIX_W-1:0]      line_m2 [MAX_W];
   logic [PIX_W-1:0]      tap [TAPS];
   int unsigned           feed_col, feed_row, emit_col, emit_row;

   result_type  pending_pixels [$];
   bit          image_done = 1'b0;
   bit          steady     = 1'b0;
   int unsigned beats_taken, beats_used, images_streamed, results_checked;
   int unsigned mismatches;
   int          stall_left = 0;

   conv3x3_zero_padded_filter #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H),
      .COEF_BITS  (COEF_W)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .req_drain      (req_drain),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_image_last (rsp_image_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned usable_size(input logic [SIZE_W-1:0] v,
                                               input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic bit in_flush();
      return feed_row >= usable_size(height_reg, MAX_H);
   endfunction

   function automatic void clear_filter_state();
      kernel_row[0] = COEF_TOP_RST;
      kernel_row[1] = COEF_MID_RST;
      kernel_row[2] = COEF_BOT_RST;
      width_reg     = WIDTH_RST;
      height_reg    = HEIGHT_RST;
      gain_reg      = GAIN_RST;
      foreach (line_m1[i]) line_m1[i] = '0;
      foreach (line_m2[i]) line_m2[i] = '0;
      foreach (tap[i]) tap[i] = '0;
      feed_col = 0;
      feed_row = 0;
      emit_col = 0;
      emit_row = 0;
   endfunction

   // Advances the shadow filter by one accepted beat and queues the pixel it produces.
   function automatic void convolve_beat(input logic [PIX_W-1:0] pix, input logic drn);
      int unsigned       w, h, c, r, k;
      bit                flushing, emit, last;
      logic [PIX_W-1:0]  value, above, above2;
      logic signed [7:0] weight;
      int                acc;
      longint            scaled;
      result_type        res;
      w = usable_size(width_reg, MAX_W);
      h = usable_size(height_reg, MAX_H);
      flushing = (feed_row >= h);
      beats_taken++;
      // A drain beat is dropped until every row of the image has come in.
      if (drn && !flushing) return;
      beats_used++;
      value  = flushing ? '0 : pix;
      c      = (feed_col < MAX_W) ? feed_col : 0;
      above2 = line_m2[c];
      above  = line_m1[c];
      for (r = 0; r < 3; r++) begin
         tap[r*3]   = tap[r*3+1];
         tap[r*3+1] = tap[r*3+2];
      end
      tap[2]     = above2;
      tap[5]     = above;
      tap[8]     = value;
      line_m2[c] = above;
      line_m1[c] = value;
      emit = (feed_row >= 2) || (feed_row == 1 && feed_col >= 1);
      if (feed_col + 1 >= w) begin
         feed_col = 0;
         if (feed_row < IN_ROW_MAX) feed_row++;
      end else begin
         feed_col++;
      end
      if (!emit) return;

      // Taps that fall outside the image are masked, which gives the zero padding.
      acc = 0;
      for (r = 0; r < 3; r++) begin
         if (r == 0 && emit_row < 1) continue;
         if (r == 2 && emit_row + 1 >= h) continue;
         for (k = 0; k < 3; k++) begin
            if (k == 0 && emit_col < 1) continue;
            if (k == 2 && emit_col + 1 >= w) continue;
            weight = kernel_row[r][k*COEF_W +: COEF_W];
            acc += int'(weight) * int'(tap[r*3+k]);
         end
      end
      if (acc <= 0) begin
         res.pixel = '0;
      end else begin
         scaled    = (longint'(acc) * longint'(gain_reg)) >>> GAIN_FRAC;
         res.pixel = (scaled > 255) ? PIX_MAX : scaled[7:0];
      end

      last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
      if (last) begin
         feed_col = 0;
         feed_row = 0;
         emit_col = 0;
         emit_row = 0;
      end else if (emit_col + 1 >= w) begin
         emit_col = 0;
         emit_row = (emit_row + 1) % 1024;
      end else begin
         emit_col++;
      end
      res.last = last;
      pending_pixels.push_back(res);
      if (last) image_done = 1'b1;
   endfunction

   function automatic void report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
   endfunction

   // Mostly short gaps, now and then a long one, none at all in steady stretches.
   function automatic int idle_span();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return PIX_MAX;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] random_coef();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 8'h80;
      if (roll < 20) return 8'h7F;
      if (roll < 35) return 8'h00;
      if (roll < 75) return 8'($urandom_range(0, 8) - 4);
      return 8'($urandom_range(0, 255));
   endfunction

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result pixel %0d last %0b",
                                      rsp_pixel_out, rsp_image_last));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel)
               report_mismatch($sformatf("result %0d pixel expected %0d got %0d",
                                         results_checked, want.pixel, rsp_pixel_out));
            if (rsp_image_last !== want.last)
               report_mismatch($sformatf("result %0d image_last expected %0b got %0b",
                                         results_checked, want.last, rsp_image_last));
            results_checked++;
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_span();
      end
   end

   // Valid is left high after a beat is taken so that back-to-back beats keep it up.
   task automatic push_beat(input logic [PIX_W-1:0] pix, input logic drn);
      int gap;
      gap = idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      req_drain    <= drn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      convolve_beat(pix, drn);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_COEF_TOP:     kernel_row[0] = data;
         CSR_COEF_MID:     kernel_row[1] = data;
         CSR_COEF_BOT:     kernel_row[2] = data;
         CSR_IMAGE_WIDTH:  width_reg     = data[SIZE_W-1:0];
         CSR_IMAGE_HEIGHT: height_reg    = data[SIZE_W-1:0];
         CSR_NORM_GAIN:    gain_reg      = data[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_kernel(input logic [CSR_DATA_W-1:0] top,
                               input logic [CSR_DATA_W-1:0] mid,
                               input logic [CSR_DATA_W-1:0] bot);
      write_csr(CSR_COEF_TOP, top);
      write_csr(CSR_COEF_MID, mid);
      write_csr(CSR_COEF_BOT, bot);
   endtask

   // Finishes the current image: pixel beats with some stray drains, then the flush.
   task automatic stream_image(input int noise_pct, input int flush_pixel_pct);
      while (!image_done) begin
         if (in_flush())
            push_beat(random_pixel(), $urandom_range(0, 99) >= flush_pixel_pct);
         else if ($urandom_range(0, 99) < noise_pct)
            push_beat(random_pixel(), 1'b1);
         else
            push_beat(random_pixel(), 1'b0);
      end
      image_done = 1'b0;
      images_streamed++;
   endtask

   task automatic shuffle_settings();
      int   roll;
      logic [GAIN_W-1:0] gain;
      roll = $urandom_range(0, 99);
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'((roll < 5) ? 0 :
                (roll < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40)));
      roll = $urandom_range(0, 99);
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'((roll < 5) ? 0 : $urandom_range(1, 6)));
      write_kernel({random_coef(), random_coef(), random_coef()},
                   {random_coef(), random_coef(), random_coef()},
                   {random_coef(), random_coef(), random_coef()});
      roll = $urandom_range(0, 99);
      if (roll < 10)      gain = '0;
      else if (roll < 20) gain = '1;
      else if (roll < 50) gain = GAIN_RST;
      else                gain = GAIN_W'($urandom_range(256, 12000));
      write_csr(CSR_NORM_GAIN, CSR_DATA_W'(gain));
   endtask

   // Identity kernel and unit gain from reset, so every result repeats its pixel.
   task automatic test_reset_settings();
      write_csr(CSR_IMAGE_WIDTH, 3);
      write_csr(CSR_IMAGE_HEIGHT, 2);
      push_beat(8'h00, 1'b1);
      push_beat(8'hFF, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h5A, 1'b0);
      push_beat(8'h33, 1'b1);
      push_beat(8'hA5, 1'b0);
      push_beat(8'h01, 1'b0);
      push_beat(8'hFE, 1'b0);
      // A pixel beat after the last row only serves as a flush beat.
      push_beat(8'hFF, 1'b0);
      stream_image(0, 0);
   endtask

   // Sizes of zero clamp to a single pixel; the kernel extremes saturate both ways.
   task automatic test_tiny_image();
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 0);
      write_csr(CSR_IMAGE_HEIGHT, 0);
      write_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
      write_csr(CSR_NORM_GAIN, 16'hFFFF);
      push_beat(8'd200, 1'b0);
      stream_image(0, 0);
      wait_idle();
      write_kernel(24'h808080, 24'h808080, 24'h808080);
      push_beat(8'hFF, 1'b0);
      stream_image(0, 0);
   endtask

   // The first result is due on the sixth beat, so the width can change before it.
   task automatic test_resize_mid_image();
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 4);
      write_csr(CSR_IMAGE_HEIGHT, 3);
      write_kernel(24'h01FF02, 24'hFE0403, 24'h0201FF);
      write_csr(CSR_NORM_GAIN, GAIN_RST);
      repeat (5) push_beat(random_pixel(), 1'b0);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 3);
      stream_image(0, 30);
   endtask

   task automatic test_random_images();
      int unsigned first;
      first = beats_used;
      while (beats_used - first < RANDOM_ITEMS) begin
         wait_idle();
         shuffle_settings();
         steady = ($urandom_range(0, 4) == 0);
         stream_image(10, 25);
      end
      steady = 1'b0;
   endtask

   // Over-range sizes are used for part of an image, then cut back so the image ends
   // within a few rows and the stream stays short.
   task automatic test_size_extremes();
      wait_idle();
      write_kernel({random_coef(), random_coef(), random_coef()},
                   {random_coef(), random_coef(), random_coef()},
                   {random_coef(), random_coef(), random_coef()});
      write_csr(CSR_NORM_GAIN, CSR_DATA_W'($urandom_range(512, 8192)));
      write_csr(CSR_IMAGE_WIDTH, 24'h7FF);
      write_csr(CSR_IMAGE_HEIGHT, 24'd2);
      repeat (30) push_beat(random_pixel(), 1'b0);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 24'd6);
      stream_image(5, 50);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 24'd5);
      write_csr(CSR_IMAGE_HEIGHT, 24'h7FF);
      repeat (20) push_beat(random_pixel(), 1'b0);
      wait_idle();
      write_csr(CSR_IMAGE_HEIGHT, 24'd3);
      stream_image(5, 50);
   endtask

   initial begin
      int n;
      clear_filter_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_tiny_image();
      test_resize_mid_image();
      test_random_images();
      test_size_extremes();

      req_valid <= 1'b0;
      n = 0;
      while (pending_pixels.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));

      $display("Checked %0d results from %0d images over %0d beats, %0d of them dropped drains.",
               results_checked, images_streamed, beats_taken, beats_taken - beats_used);
      $display("Sizes ranged from one pixel to over-range values cut back mid-image, %s",
               "with kernel and gain extremes.");
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> conv3x3_zero_padded_filter.f
hdl/c3zp_pkg.sv
hdl/c3zp_ram.sv
hdl/c3zp_ctrl.sv
hdl/c3zp_datapath.sv
hdl/c3zp_outq.sv
hdl/conv3x3_zero_padded_filter.sv
bench/testbench.sv
